// ===== src/sso_pkg.sv =====
// Shared types, constants and the sine table for the servo sine oscillator.
package sso_pkg;

    // Sine table geometry
    localparam int SINE_INDEX_BITS    = 10;
    localparam int SINE_FRACTION_BITS = 15;
    localparam int SINE_SIZE          = 1 << SINE_INDEX_BITS;
    // Entries span -1.0 .. +1.0 inclusive, so one bit above the fraction plus sign
    localparam int SINE_ENTRY_W       = SINE_FRACTION_BITS + 2;

    // Field widths
    localparam int TIME_W      = 32;
    localparam int PHASE_W     = 32;
    localparam int PERIOD_W    = 16;
    localparam int AMP_W       = 7;
    localparam int OFFSET_W    = 8;
    localparam int POFF_W      = 16;
    localparam int INTERVAL_W  = 10;
    localparam int ANGLE_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Scaling datapath widths
    localparam int PRODUCT_W   = SINE_ENTRY_W + AMP_W + 1;
    localparam int DEG_W       = PRODUCT_W + 2 - SINE_FRACTION_BITS;
    localparam int ANGLE_SUM_W = DEG_W + 1;

    // Angle limits
    localparam int CENTER_DEG = 90;
    localparam int MAX_ANGLE  = 180;

    // Step divider: dividend is interval << 32, one quotient bit per cycle
    localparam int DIV_STEPS   = INTERVAL_W + PHASE_W;
    localparam int DIV_COUNT_W = $clog2(DIV_STEPS + 1);

    // Reset values of the registers
    localparam logic [PERIOD_W-1:0]   RESET_PERIOD_MS   = PERIOD_W'(2000);
    localparam logic [AMP_W-1:0]      RESET_AMPLITUDE   = AMP_W'(45);
    localparam logic [OFFSET_W-1:0]   RESET_OFFSET      = '0;
    localparam logic [POFF_W-1:0]     RESET_PHASE_OFF   = '0;
    localparam logic [INTERVAL_W-1:0] RESET_INTERVAL_MS = INTERVAL_W'(30);
    localparam logic [63:0] RESET_STEP_WIDE =
        (64'(RESET_INTERVAL_MS) << PHASE_W) / 64'(RESET_PERIOD_MS);
    localparam logic [PHASE_W-1:0] RESET_STEP = RESET_STEP_WIDE[PHASE_W-1:0];

    // Register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PERIOD   = 3'd0,
        CFG_AMPLITUDE = 3'd1,
        CFG_OFFSET   = 3'd2,
        CFG_PHASE    = 3'd3,
        CFG_INTERVAL = 3'd4
    } cfg_index_t;

    // Step divider status toward the top level
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [PHASE_W-1:0] quotient;
    } step_div_status_t;

    typedef logic signed [SINE_ENTRY_W-1:0] sine_table_t [SINE_SIZE];

    // Q30 arithmetic used to build the table at elaboration
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // One Horner step: t = 1 - x2 * t / n, floored at zero
    function automatic logic [63:0] horner_clip(input logic [63:0] d);
        return (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
    endfunction

    // sin(x) for x in [0, pi/2], Taylor series to x^13, unsigned Q30
    function automatic logic [63:0] sin_quarter_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = horner_clip(((x2 * t) >> 30) / 156);
        t  = horner_clip(((x2 * t) >> 30) / 110);
        t  = horner_clip(((x2 * t) >> 30) / 72);
        t  = horner_clip(((x2 * t) >> 30) / 42);
        t  = horner_clip(((x2 * t) >> 30) / 20);
        t  = horner_clip(((x2 * t) >> 30) / 6);
        return (x * t) >> 30;
    endfunction

    // Full-turn table from quadrant symmetry, rounded half up to the fraction
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] r;
        int unsigned quarter;
        int unsigned j;
        int unsigned k;
        quarter = SINE_SIZE >> 2;
        for (int unsigned i = 0; i < SINE_SIZE; i++) begin
            j = i & (2 * quarter - 1);
            k = (j <= quarter) ? j : 2 * quarter - j;
            x = (64'(k) * 64'd2 * PI_Q30) >> SINE_INDEX_BITS;
            s = sin_quarter_q30(x);
            r = (s + (64'd1 << (29 - SINE_FRACTION_BITS))) >> (30 - SINE_FRACTION_BITS);
            tbl[i] = (i >= 2 * quarter) ? -SINE_ENTRY_W'(r) : SINE_ENTRY_W'(r);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ===== src/sso_step_div.sv =====
// Bit-serial restoring divider that derives the phase step from interval and period.
module sso_step_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sso_pkg::INTERVAL_W-1:0] interval,
    input  logic [sso_pkg::PERIOD_W-1:0]   period,
    output sso_pkg::step_div_status_t      status
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [sso_pkg::DIV_COUNT_W-1:0] count_reg;
    logic [sso_pkg::DIV_STEPS-1:0]   num_reg;
    logic [sso_pkg::PERIOD_W-1:0]    divisor_reg;
    logic [sso_pkg::PERIOD_W-1:0]    rem_reg;
    logic [sso_pkg::PHASE_W-1:0]     quot_reg;

    logic [sso_pkg::PERIOD_W:0]      partial;
    logic [sso_pkg::PERIOD_W:0]      diff;
    logic                            fits;
    logic [sso_pkg::PERIOD_W-1:0]    rem_next;
    logic                            last_step;

    // One trial subtraction per cycle
    always_comb
    begin
        partial   = {rem_reg, num_reg[sso_pkg::DIV_STEPS-1]};
        diff      = partial - {1'b0, divisor_reg};
        fits      = partial >= {1'b0, divisor_reg};
        rem_next  = fits ? diff[sso_pkg::PERIOD_W-1:0] : partial[sso_pkg::PERIOD_W-1:0];
        last_step = count_reg == sso_pkg::DIV_COUNT_W'(sso_pkg::DIV_STEPS - 1);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + sso_pkg::DIV_COUNT_W'(1);
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath; quotient keeps the low 32 bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg     <= {interval, {sso_pkg::PHASE_W{1'b0}}};
            divisor_reg <= period;
            rem_reg     <= '0;
            quot_reg    <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[sso_pkg::DIV_STEPS-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[sso_pkg::PHASE_W-2:0], fits};
        end
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.quotient = quot_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> count_reg < sso_pkg::DIV_COUNT_W'(sso_pkg::DIV_STEPS))
        else $error("divider count ran past its last step");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");

endmodule

// ===== src/sso_sine_rom.sv =====
// Sine table with one registered read port.
module sso_sine_rom (
    input  logic                                clk,
    input  logic                                read_en,
    input  logic [sso_pkg::SINE_INDEX_BITS-1:0] addr,
    output logic signed [sso_pkg::SINE_ENTRY_W-1:0] data
);

    logic signed [sso_pkg::SINE_ENTRY_W-1:0] data_reg;

    // Registered read; holds while the next stage is stalled
    always_ff @(posedge clk)
    begin
        if (read_en)
            data_reg <= sso_pkg::SINE_TABLE[addr];
    end

    assign data = data_reg;

endmodule

// ===== src/sso_angle.sv =====
// Scales the sine sample, rounds to whole degrees, centers, clamps, and holds the result.
module sso_angle (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   entry_valid,
    input  logic signed [sso_pkg::SINE_ENTRY_W-1:0] entry,
    input  logic [sso_pkg::AMP_W-1:0]              amplitude_deg,
    input  logic [sso_pkg::OFFSET_W-1:0]           center_offset_deg,
    output logic                                   entry_take,
    output logic                                   angle_valid,
    input  logic                                   angle_stall,
    output logic [sso_pkg::ANGLE_W-1:0]            servo_angle
);

    localparam int PW = sso_pkg::PRODUCT_W;
    localparam int SF = sso_pkg::SINE_FRACTION_BITS;

    logic                                 prod_valid_reg;
    logic signed [PW-1:0]                 prod_reg;
    logic                                 out_valid_reg;
    logic [sso_pkg::ANGLE_W-1:0]          angle_reg;

    logic                                 en_out;
    logic                                 en_prod;
    logic signed [PW-1:0]                 amp_ext;
    logic signed [PW-1:0]                 entry_ext;
    logic signed [PW-1:0]                 bias;
    logic signed [PW-1:0]                 prod_next;
    logic                                 neg;
    logic [PW-1:0]                        mag;
    logic [PW:0]                          rounded;
    logic [sso_pkg::DEG_W-2:0]            deg_mag;
    logic signed [sso_pkg::DEG_W-1:0]     deg;
    logic signed [sso_pkg::ANGLE_SUM_W-1:0] angle_sum;
    logic [sso_pkg::ANGLE_W-1:0]          angle_next;

    // Stage enables: a stage moves when it is empty or its successor moves
    assign en_out     = !out_valid_reg || !angle_stall;
    assign en_prod    = !prod_valid_reg || en_out;
    assign entry_take = en_prod;

    // amplitude * sin + offset, exact in the fraction format
    always_comb
    begin
        amp_ext   = $signed({{(PW - sso_pkg::AMP_W){1'b0}}, amplitude_deg});
        entry_ext = $signed({{(PW - sso_pkg::SINE_ENTRY_W){entry[sso_pkg::SINE_ENTRY_W-1]}},
                             entry});
        bias      = $signed({{(PW - sso_pkg::OFFSET_W - SF)
                               {center_offset_deg[sso_pkg::OFFSET_W-1]}},
                             center_offset_deg, {SF{1'b0}}});
        prod_next = amp_ext * entry_ext + bias;
    end

    // Round half away from zero, add center, clamp to the servo range
    always_comb
    begin
        neg       = prod_reg[PW-1];
        mag       = neg ? PW'(-prod_reg) : PW'(prod_reg);
        rounded   = {1'b0, mag} + ((PW + 1)'(1) << (SF - 1));
        deg_mag   = rounded[PW:SF];
        deg       = neg ? -$signed({1'b0, deg_mag}) : $signed({1'b0, deg_mag});
        angle_sum = $signed({deg[sso_pkg::DEG_W-1], deg})
                    + $signed(sso_pkg::ANGLE_SUM_W'(sso_pkg::CENTER_DEG));
        priority if (angle_sum < 0)
            angle_next = '0;
        else if (angle_sum > $signed(sso_pkg::ANGLE_SUM_W'(sso_pkg::MAX_ANGLE)))
            angle_next = sso_pkg::ANGLE_W'(sso_pkg::MAX_ANGLE);
        else
            angle_next = angle_sum[sso_pkg::ANGLE_W-1:0];
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en_prod)
                prod_valid_reg <= entry_valid;
            if (en_out)
                out_valid_reg <= prod_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en_prod && entry_valid)
            prod_reg <= prod_next;
        if (en_out && prod_valid_reg)
            angle_reg <= angle_next;
    end

    assign angle_valid = out_valid_reg;
    assign servo_angle = angle_reg;

    // Checks
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> angle_reg <= sso_pkg::ANGLE_W'(sso_pkg::MAX_ANGLE))
        else $error("servo angle outside 0..180");
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && !en_out |=> prod_valid_reg && $stable(prod_reg))
        else $error("product stage lost its transaction under stall");
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && en_out |=> out_valid_reg)
        else $error("output register did not take the product stage");

endmodule

// ===== src/servo_sine_oscillator_unit.sv =====
// Top level of the servo sine oscillator: registers, phase state and stage control.
//
// Each sample transaction carries the current millisecond time. When more than
// update_interval_ms have passed since the last recorded update, the block records
// the time and issues one servo angle, amplitude*sin(phase)+offset rounded to whole
// degrees, centered at 90 and clamped to 0..180; the phase then advances by a step
// of interval/period turns. One sample is taken per clock unless stalled.
// A triggering sample's angle reaches servo_angle through three registers: sine
// table read at the accepting edge, scaling multiply, round and clamp into the
// output register. Writing period_ms or update_interval_ms starts a bit-serial
// division of the phase step; sample_stall is high and cfg_ready is low until
// the new step is loaded.
// Back-pressure on the angle channel stalls the three stages in turn and reaches
// sample_stall only when they are all full.
module servo_sine_oscillator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [sso_pkg::TIME_W-1:0]      now_ms,
    output logic                            angle_valid,
    input  logic                            angle_stall,
    output logic [sso_pkg::ANGLE_W-1:0]     servo_angle,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sso_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sso_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [sso_pkg::PERIOD_W-1:0]   period_reg,   period_next;
    logic [sso_pkg::AMP_W-1:0]      amp_reg,      amp_next;
    logic [sso_pkg::OFFSET_W-1:0]   offset_reg,   offset_next;
    logic [sso_pkg::POFF_W-1:0]     poff_reg,     poff_next;
    logic [sso_pkg::INTERVAL_W-1:0] interval_reg, interval_next;

    // Oscillator state
    logic [sso_pkg::TIME_W-1:0]     last_time_reg;
    logic [sso_pkg::PHASE_W-1:0]    acc_reg;
    logic [sso_pkg::PHASE_W-1:0]    step_reg;
    logic                           s1_valid_reg;

    logic                           cfg_fire;
    logic                           div_start;
    logic                           div_active;
    sso_pkg::step_div_status_t      div_status;

    logic                           sample_fire;
    logic                           trigger;
    logic [sso_pkg::TIME_W-1:0]     elapsed;
    logic [sso_pkg::PHASE_W-1:0]    phase;
    logic                           en_s1;
    logic                           entry_take;
    logic signed [sso_pkg::SINE_ENTRY_W-1:0] rom_data;

    // Register writes
    assign cfg_ready = !div_active;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        period_next   = period_reg;
        amp_next      = amp_reg;
        offset_next   = offset_reg;
        poff_next     = poff_reg;
        interval_next = interval_reg;
        div_start     = 1'b0;
        if (cfg_fire)
        begin
            unique case (sso_pkg::cfg_index_t'(cfg_index))
                sso_pkg::CFG_PERIOD:
                begin
                    // A zero period counts as one
                    period_next = (cfg_data == '0) ? sso_pkg::PERIOD_W'(1)
                                                   : cfg_data[sso_pkg::PERIOD_W-1:0];
                    div_start   = 1'b1;
                end
                sso_pkg::CFG_AMPLITUDE:
                    amp_next = cfg_data[sso_pkg::AMP_W-1:0];
                sso_pkg::CFG_OFFSET:
                    offset_next = cfg_data[sso_pkg::OFFSET_W-1:0];
                sso_pkg::CFG_PHASE:
                    poff_next = cfg_data[sso_pkg::POFF_W-1:0];
                sso_pkg::CFG_INTERVAL:
                begin
                    interval_next = cfg_data[sso_pkg::INTERVAL_W-1:0];
                    div_start     = 1'b1;
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= sso_pkg::RESET_PERIOD_MS;
            amp_reg      <= sso_pkg::RESET_AMPLITUDE;
            offset_reg   <= sso_pkg::RESET_OFFSET;
            poff_reg     <= sso_pkg::RESET_PHASE_OFF;
            interval_reg <= sso_pkg::RESET_INTERVAL_MS;
        end
        else
        begin
            period_reg   <= period_next;
            amp_reg      <= amp_next;
            offset_reg   <= offset_next;
            poff_reg     <= poff_next;
            interval_reg <= interval_next;
        end
    end

    // Phase step division
    sso_step_div u_step_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .interval (interval_next),
        .period   (period_next),
        .status   (div_status)
    );

    assign div_active = div_status.busy || div_status.done;

    // Sample acceptance and update decision
    assign en_s1        = !s1_valid_reg || entry_take;
    assign sample_stall = !en_s1 || div_active;
    assign sample_fire  = sample_valid && !sample_stall;

    always_comb
    begin
        elapsed = now_ms - last_time_reg;
        trigger = elapsed > {{(sso_pkg::TIME_W - sso_pkg::INTERVAL_W){1'b0}}, interval_reg};
        phase   = acc_reg + {poff_reg, {(sso_pkg::PHASE_W - sso_pkg::POFF_W){1'b0}}};
    end

    // State update and first stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            acc_reg       <= '0;
            step_reg      <= sso_pkg::RESET_STEP;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (div_status.done)
                step_reg <= div_status.quotient;
            if (sample_fire && trigger)
            begin
                last_time_reg <= now_ms;
                acc_reg       <= acc_reg + step_reg;
            end
            if (en_s1)
                s1_valid_reg <= sample_fire && trigger;
        end
    end

    // Sine lookup from the top phase bits
    sso_sine_rom u_sine_rom (
        .clk     (clk),
        .read_en (en_s1),
        .addr    (phase[sso_pkg::PHASE_W-1 -: sso_pkg::SINE_INDEX_BITS]),
        .data    (rom_data)
    );

    // Scaling, rounding and output register
    sso_angle u_angle (
        .clk               (clk),
        .rst_n             (rst_n),
        .entry_valid       (s1_valid_reg),
        .entry             (rom_data),
        .amplitude_deg     (amp_reg),
        .center_offset_deg (offset_reg),
        .entry_take        (entry_take),
        .angle_valid       (angle_valid),
        .angle_stall       (angle_stall),
        .servo_angle       (servo_angle)
    );

    // Checks
    a_trigger_enters: assert property (@(posedge clk) disable iff (!rst_n)
        sample_fire && trigger |=> s1_valid_reg)
        else $error("triggering sample did not enter the pipeline");
    a_rom_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !entry_take |=> s1_valid_reg && $stable(rom_data))
        else $error("sine stage lost its transaction under stall");
    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg != '0)
        else $error("period register holds zero");
    a_step_write_divides: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_active && !cfg_ready)
        else $error("step write did not start the divider");

endmodule
